/* rtl/eso_pkg.sv */
`timescale 1ns / 1ps

package eso_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 48;
  localparam int DT_W       = 24;
  localparam int FRAC_W     = 16;
  localparam int ERR_W      = DATA_W + 1;
  localparam int PROD_W     = 48;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int SH_SHORT = 16;
  localparam int SH_LONG  = 24;

  localparam int MUL_A_W   = 50;
  localparam int MUL_B_W   = 34;
  localparam int MUL_CH_W  = 17;
  localparam int MUL_CH_N  = 3;
  localparam int MUL_MAG_W = MUL_CH_W * MUL_CH_N;
  localparam int MUL_PP_W  = MUL_CH_W + MUL_B_W;
  localparam int MUL_ACC_W = MUL_MAG_W + MUL_B_W;
  localparam int MUL_CNT_W = 3;

  localparam int DIV_N_W   = ERR_W + FRAC_W;
  localparam int DIV_D_W   = GAIN_W;
  localparam int DIV_MAG_W = 48;
  localparam int DIV_Q_W   = DIV_MAG_W + 1;
  localparam int DIV_CNT_W = 5;

  typedef logic signed [DATA_W-1:0]     data_t;
  typedef logic signed [GAIN_W-1:0]     gain_t;
  typedef logic        [GAIN_W-1:0]     ugain_t;
  typedef logic        [DT_W-1:0]       dt_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  typedef logic signed [MUL_A_W-1:0]    mul_a_t;
  typedef logic signed [MUL_B_W-1:0]    mul_b_t;
  typedef logic        [MUL_B_W-1:0]    mul_bmag_t;
  typedef logic        [MUL_MAG_W-1:0]  mul_mag_t;
  typedef logic        [MUL_CH_W-1:0]   mul_ch_t;
  typedef logic        [MUL_PP_W-1:0]   mul_pp_t;
  typedef logic        [MUL_ACC_W-1:0]  mul_acc_t;
  typedef logic        [MUL_ACC_W:0]    mul_rnd_t;
  typedef logic        [MUL_CNT_W-1:0]  mul_cnt_t;
  typedef logic        [PROD_W-2:0]     prod_mag_t;

  typedef logic signed [DIV_N_W-1:0]    div_n_t;
  typedef logic signed [DIV_Q_W-1:0]    div_q_t;
  typedef logic        [DIV_N_W-1:0]    div_nreg_t;
  typedef logic        [DIV_D_W-1:0]    div_dreg_t;
  typedef logic        [DIV_MAG_W-1:0]  div_mag_t;
  typedef logic        [DIV_MAG_W:0]    div_trial_t;
  typedef logic        [DIV_CNT_W-1:0]  div_cnt_t;

  typedef struct packed {
    logic start;
    logic sh_long;
  } mul_req_t;

  localparam mul_cnt_t MUL_LAST = mul_cnt_t'(MUL_CH_N + 1);
  localparam div_cnt_t DIV_LAST = div_cnt_t'(DIV_MAG_W / 2 + 1);

  localparam mul_rnd_t MUL_RND_SHORT = {{MUL_ACC_W{1'b0}}, 1'b1} << (SH_SHORT - 1);
  localparam mul_rnd_t MUL_RND_LONG  = {{MUL_ACC_W{1'b0}}, 1'b1} << (SH_LONG - 1);
  localparam prod_mag_t PROD_LIM     = '1;

  localparam cfg_idx_t CFG_INPUT_GAIN   = 3'd0;
  localparam cfg_idx_t CFG_GAIN_ONE     = 3'd1;
  localparam cfg_idx_t CFG_GAIN_TWO     = 3'd2;
  localparam cfg_idx_t CFG_GAIN_THREE   = 3'd3;
  localparam cfg_idx_t CFG_DIST_FLOOR   = 3'd4;
  localparam cfg_idx_t CFG_DIST_CEILING = 3'd5;
  localparam cfg_idx_t CFG_DIST_SCALE   = 3'd6;

  localparam gain_t INPUT_GAIN_RST = gain_t'(65536);
  localparam data_t DIST_FLOOR_RST = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t DIST_CEIL_RST  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DIST_SCALE_RST = data_t'(65536);

endpackage

/* rtl/eso_mul.sv */
`timescale 1ns / 1ps

module eso_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  eso_pkg::mul_req_t  req,
  input  eso_pkg::mul_a_t    a,
  input  eso_pkg::mul_b_t    b,
  output logic               done,
  output eso_pkg::prod_t     res
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  eso_pkg::mul_cnt_t   cnt_r, cnt_nxt;
  eso_pkg::mul_mag_t   a_r, a_nxt;
  eso_pkg::mul_bmag_t  b_r, b_nxt;
  eso_pkg::mul_acc_t   acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                long_r, long_nxt;
  eso_pkg::prod_t      res_r, res_nxt;

  eso_pkg::mul_ch_t    chunk;
  eso_pkg::mul_pp_t    pp;
  eso_pkg::mul_rnd_t   rnd_sum;
  eso_pkg::mul_rnd_t   shifted;
  eso_pkg::prod_mag_t  mag;

  assign chunk   = a_r[eso_pkg::MUL_MAG_W-1 -: eso_pkg::MUL_CH_W];
  assign pp      = chunk * b_r;
  assign rnd_sum = {1'b0, acc_r} + (long_r ? eso_pkg::MUL_RND_LONG : eso_pkg::MUL_RND_SHORT);
  assign shifted = long_r ? (rnd_sum >> eso_pkg::SH_LONG) : (rnd_sum >> eso_pkg::SH_SHORT);
  assign mag     = (|shifted[eso_pkg::MUL_ACC_W:eso_pkg::PROD_W-1]) ? eso_pkg::PROD_LIM :
                   shifted[eso_pkg::PROD_W-2:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    long_nxt = long_r;
    res_nxt  = res_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = eso_pkg::mul_mag_t'(a);
      b_nxt    = b;
      neg_nxt  = a[eso_pkg::MUL_A_W-1] ^ b[eso_pkg::MUL_B_W-1];
      long_nxt = req.sh_long;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + eso_pkg::mul_cnt_t'(1);
      if (cnt_r == '0) begin
        a_nxt   = a_r[eso_pkg::MUL_MAG_W-1] ? -a_r : a_r;
        b_nxt   = b_r[eso_pkg::MUL_B_W-1] ? -b_r : b_r;
        acc_nxt = '0;
      end else if (cnt_r == eso_pkg::MUL_LAST) begin
        res_nxt  = neg_r ? -eso_pkg::prod_t'({1'b0, mag}) : eso_pkg::prod_t'({1'b0, mag});
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = (acc_r << eso_pkg::MUL_CH_W) + eso_pkg::mul_acc_t'(pp);
        a_nxt   = a_r << eso_pkg::MUL_CH_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    long_r <= long_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/eso_div.sv */
`timescale 1ns / 1ps

module eso_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  eso_pkg::div_n_t  num,
  input  eso_pkg::gain_t   den,
  output logic             done,
  output eso_pkg::div_q_t  quo
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  eso_pkg::div_cnt_t   cnt_r, cnt_nxt;
  eso_pkg::div_nreg_t  num_r, num_nxt;
  eso_pkg::div_dreg_t  den_r, den_nxt;
  eso_pkg::div_mag_t   rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  eso_pkg::div_q_t     quo_r, quo_nxt;

  eso_pkg::div_mag_t   rem_v;
  eso_pkg::div_mag_t   num_v;
  eso_pkg::div_trial_t trial;

  always_comb begin
    rem_v = rem_r;
    num_v = num_r[eso_pkg::DIV_MAG_W-1:0];
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, num_v[eso_pkg::DIV_MAG_W-1]};
      num_v = {num_v[eso_pkg::DIV_MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_v    = eso_pkg::div_mag_t'(trial - {1'b0, den_r});
        num_v[0] = 1'b1;
      end else begin
        rem_v = trial[eso_pkg::DIV_MAG_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      neg_nxt  = num[eso_pkg::DIV_N_W-1] ^ den[eso_pkg::DIV_D_W-1];
    end else if (busy_r) begin
      cnt_nxt = cnt_r + eso_pkg::div_cnt_t'(1);
      if (cnt_r == '0) begin
        num_nxt = num_r[eso_pkg::DIV_N_W-1] ? -num_r : num_r;
        den_nxt = den_r[eso_pkg::DIV_D_W-1] ? -den_r : den_r;
        rem_nxt = '0;
      end else if (cnt_r == eso_pkg::DIV_LAST) begin
        quo_nxt  = neg_r ? -eso_pkg::div_q_t'(num_r[eso_pkg::DIV_MAG_W-1:0]) :
                   eso_pkg::div_q_t'(num_r[eso_pkg::DIV_MAG_W-1:0]);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        num_nxt = eso_pkg::div_nreg_t'(num_v);
        rem_nxt = rem_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/extended_state_observer.sv */
`timescale 1ns / 1ps

// Third-order linear extended state observer in Q16.16 with Q32.16 gains and a Q0.24 step.
// Each request advances the estimates z1, z2, z3 by one Euler step and returns them with
// the clamped disturbance estimate -z3/b0 times the scale; a zero input gain skips the
// divider and gives a zero quotient. One request is in work at a time: the work is
// eight products through the one shared multiplier and the divider, which retires two
// quotient bits a cycle. A finished result waits in the output register while the next
// request is taken. Write configuration only while idle.
module extended_state_observer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  eso_pkg::cfg_idx_t    cfg_index,
  input  eso_pkg::cfg_data_t   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eso_pkg::data_t       in_control_in,
  input  eso_pkg::data_t       in_measured,
  input  eso_pkg::dt_t         in_step_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eso_pkg::data_t       out_est_one,
  output eso_pkg::data_t       out_est_two,
  output eso_pkg::data_t       out_est_three,
  output eso_pkg::data_t       out_disturb_est
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  localparam logic [3:0] OP_P1  = 4'd0;
  localparam logic [3:0] OP_PU  = 4'd1;
  localparam logic [3:0] OP_P2  = 4'd2;
  localparam logic [3:0] OP_P3  = 4'd3;
  localparam logic [3:0] OP_D1  = 4'd4;
  localparam logic [3:0] OP_D2  = 4'd5;
  localparam logic [3:0] OP_D3  = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_DS  = 4'd8;

  function automatic eso_pkg::data_t sat_data(input eso_pkg::sum_t v);
    logic hi_any;
    logic hi_all;
    hi_any = |v[eso_pkg::SUM_W-2:eso_pkg::DATA_W-1];
    hi_all = &v[eso_pkg::SUM_W-2:eso_pkg::DATA_W-1];
    if (!v[eso_pkg::SUM_W-1] && hi_any) begin
      sat_data = {1'b0, {(eso_pkg::DATA_W-1){1'b1}}};
    end else if (v[eso_pkg::SUM_W-1] && !hi_all) begin
      sat_data = {1'b1, {(eso_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_data = v[eso_pkg::DATA_W-1:0];
    end
  endfunction

  eso_pkg::gain_t   input_gain_r;
  eso_pkg::ugain_t  gain_one_r, gain_two_r, gain_three_r;
  eso_pkg::data_t   floor_r, ceil_r, scale_r;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       op_r, op_nxt;
  eso_pkg::data_t   u_r, u_nxt;
  eso_pkg::dt_t     dt_r, dt_nxt;
  eso_pkg::err_t    e_r, e_nxt;
  eso_pkg::data_t   first_r, first_nxt;
  eso_pkg::data_t   second_r, second_nxt;
  eso_pkg::data_t   third_r, third_nxt;
  eso_pkg::prod_t   p1_r, p1_nxt;
  eso_pkg::prod_t   pu_r, pu_nxt;
  eso_pkg::prod_t   p2_r, p2_nxt;
  eso_pkg::prod_t   p3_r, p3_nxt;
  eso_pkg::div_q_t  q_r, q_nxt;
  eso_pkg::prod_t   d_r, d_nxt;
  logic             out_valid_r, out_valid_nxt;
  eso_pkg::data_t   out_one_r, out_one_nxt;
  eso_pkg::data_t   out_two_r, out_two_nxt;
  eso_pkg::data_t   out_three_r, out_three_nxt;
  eso_pkg::data_t   out_dist_r, out_dist_nxt;

  eso_pkg::mul_req_t mul_req;
  logic              mul_start;
  logic              mul_long;
  eso_pkg::mul_a_t   mul_a;
  eso_pkg::mul_b_t   mul_b;
  logic              mul_done;
  eso_pkg::prod_t    mul_res;
  logic              div_start;
  eso_pkg::div_n_t   div_num;
  logic              div_done;
  eso_pkg::div_q_t   div_quo;

  eso_pkg::err_t     third_neg;
  eso_pkg::sum_t     sum_one, sum_two, sum_three;
  eso_pkg::data_t    dist_clamped;
  logic              unit_done;

  eso_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  eso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (input_gain_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mul_req   = eso_pkg::mul_req_t'({mul_start, mul_long});
  assign third_neg = -eso_pkg::err_t'(third_r);
  assign div_num   = {third_neg, {eso_pkg::FRAC_W{1'b0}}};
  assign sum_one   = eso_pkg::sum_t'(first_r) + eso_pkg::sum_t'(mul_res);
  assign sum_two   = eso_pkg::sum_t'(second_r) + eso_pkg::sum_t'(mul_res);
  assign sum_three = eso_pkg::sum_t'(third_r) - eso_pkg::sum_t'(mul_res);
  assign unit_done = (op_r == OP_DIV) ? div_done : mul_done;

  always_comb begin
    if (d_r < eso_pkg::prod_t'(floor_r)) begin
      dist_clamped = floor_r;
    end else if (d_r > eso_pkg::prod_t'(ceil_r)) begin
      dist_clamped = ceil_r;
    end else begin
      dist_clamped = d_r[eso_pkg::DATA_W-1:0];
    end
  end

  always_comb begin
    mul_long = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (op_r)
      OP_P1: begin
        mul_a = eso_pkg::mul_a_t'(gain_one_r);
        mul_b = eso_pkg::mul_b_t'(e_r);
      end
      OP_PU: begin
        mul_a = eso_pkg::mul_a_t'(input_gain_r);
        mul_b = eso_pkg::mul_b_t'(u_r);
      end
      OP_P2: begin
        mul_a = eso_pkg::mul_a_t'(gain_two_r);
        mul_b = eso_pkg::mul_b_t'(e_r);
      end
      OP_P3: begin
        mul_a = eso_pkg::mul_a_t'(gain_three_r);
        mul_b = eso_pkg::mul_b_t'(e_r);
      end
      OP_D1: begin
        mul_long = 1'b1;
        mul_a = eso_pkg::mul_a_t'(second_r) - eso_pkg::mul_a_t'(p1_r);
        mul_b = eso_pkg::mul_b_t'(dt_r);
      end
      OP_D2: begin
        mul_long = 1'b1;
        mul_a = eso_pkg::mul_a_t'(third_r) + eso_pkg::mul_a_t'(pu_r) -
                eso_pkg::mul_a_t'(p2_r);
        mul_b = eso_pkg::mul_b_t'(dt_r);
      end
      OP_D3: begin
        mul_long = 1'b1;
        mul_a = eso_pkg::mul_a_t'(p3_r);
        mul_b = eso_pkg::mul_b_t'(dt_r);
      end
      OP_DS: begin
        mul_a = eso_pkg::mul_a_t'(q_r);
        mul_b = eso_pkg::mul_b_t'(scale_r);
      end
      default: begin
        mul_long = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    u_nxt         = u_r;
    dt_nxt        = dt_r;
    e_nxt         = e_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    third_nxt     = third_r;
    p1_nxt        = p1_r;
    pu_nxt        = pu_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    q_nxt         = q_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_one_nxt   = out_one_r;
    out_two_nxt   = out_two_r;
    out_three_nxt = out_three_r;
    out_dist_nxt  = out_dist_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          u_nxt     = in_control_in;
          dt_nxt    = in_step_time;
          e_nxt     = eso_pkg::err_t'(first_r) - eso_pkg::err_t'(in_measured);
          op_nxt    = OP_P1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (op_r == OP_DIV) begin
          if (input_gain_r == '0) begin
            q_nxt  = '0;
            op_nxt = OP_DS;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_WAIT;
          end
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          op_nxt    = op_r + 4'd1;
          state_nxt = ST_ISSUE;
          case (op_r)
            OP_P1:  p1_nxt = mul_res;
            OP_PU:  pu_nxt = mul_res;
            OP_P2:  p2_nxt = mul_res;
            OP_P3:  p3_nxt = mul_res;
            OP_D1:  first_nxt = sat_data(sum_one);
            OP_D2:  second_nxt = sat_data(sum_two);
            OP_D3:  third_nxt = sat_data(sum_three);
            OP_DIV: q_nxt = div_quo;
            OP_DS: begin
              d_nxt     = mul_res;
              op_nxt    = op_r;
              state_nxt = ST_FINISH;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_one_nxt   = first_r;
          out_two_nxt   = second_r;
          out_three_nxt = third_r;
          out_dist_nxt  = dist_clamped;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_gain_r <= eso_pkg::INPUT_GAIN_RST;
      gain_one_r   <= '0;
      gain_two_r   <= '0;
      gain_three_r <= '0;
      floor_r      <= eso_pkg::DIST_FLOOR_RST;
      ceil_r       <= eso_pkg::DIST_CEIL_RST;
      scale_r      <= eso_pkg::DIST_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        eso_pkg::CFG_INPUT_GAIN:   input_gain_r <= cfg_data;
        eso_pkg::CFG_GAIN_ONE:     gain_one_r   <= cfg_data;
        eso_pkg::CFG_GAIN_TWO:     gain_two_r   <= cfg_data;
        eso_pkg::CFG_GAIN_THREE:   gain_three_r <= cfg_data;
        eso_pkg::CFG_DIST_FLOOR:   floor_r      <= cfg_data[eso_pkg::DATA_W-1:0];
        eso_pkg::CFG_DIST_CEILING: ceil_r       <= cfg_data[eso_pkg::DATA_W-1:0];
        eso_pkg::CFG_DIST_SCALE:   scale_r      <= cfg_data[eso_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_P1;
      first_r     <= '0;
      second_r    <= '0;
      third_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      third_r     <= third_nxt;
      out_valid_r <= out_valid_nxt;
    end
    u_r         <= u_nxt;
    dt_r        <= dt_nxt;
    e_r         <= e_nxt;
    p1_r        <= p1_nxt;
    pu_r        <= pu_nxt;
    p2_r        <= p2_nxt;
    p3_r        <= p3_nxt;
    q_r         <= q_nxt;
    d_r         <= d_nxt;
    out_one_r   <= out_one_nxt;
    out_two_r   <= out_two_nxt;
    out_three_r <= out_three_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_est_one     = out_one_r;
  assign out_est_two     = out_two_r;
  assign out_est_three   = out_three_r;
  assign out_disturb_est = out_dist_r;

endmodule
